### rtl/core/assert_macros.svh
// assertion helpers for the qualifier rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/core/gcq_pkg.sv
package gcq_pkg;

  typedef enum logic [2:0] {
    ACT_NONE          = 3'd0,
    ACT_POWER_CONFIRM = 3'd1,
    ACT_GO_INTRO      = 3'd2,
    ACT_GO_INTERVIEW  = 3'd3,
    ACT_PROFILE_NEAR  = 3'd4,
    ACT_PROFILE_FAR   = 3'd5
  } action_t;

  localparam logic [2:0] LABEL_ILOVEYOU    = 3'd1;
  localparam logic [2:0] LABEL_OPEN_PALM   = 3'd2;
  localparam logic [2:0] LABEL_CLOSED_FIST = 3'd3;
  localparam logic [2:0] LABEL_POINT_UP    = 3'd4;

  localparam logic [2:0] POSE_FACE      = 3'd0;
  localparam logic [2:0] POSE_INTRO     = 3'd1;
  localparam logic [2:0] POSE_INTERVIEW = 3'd2;

  localparam logic       SIDE_NEAR = 1'b0;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_US     = 2'd2;

  localparam logic [9:0]  RST_SCORE_THRESHOLD = 10'd717;
  localparam logic [3:0]  RST_CONFIRM_COUNT   = 4'd3;
  localparam logic [31:0] RST_COOLDOWN_US     = 32'd1500000;

  localparam logic [3:0]  RUN_MAX = 4'd15;

  typedef struct packed {
    logic [9:0]  score_threshold;
    logic [3:0]  confirm_count;
    logic [31:0] cooldown_us;
  } cfg_t;

  typedef struct packed {
    logic        hand_side;
    logic [2:0]  label_code;
    logic [9:0]  score_q;
    logic [2:0]  pose_mode;
    logic [31:0] generation;
    logic [63:0] time_us;
  } item_t;

  typedef struct packed {
    logic step;
    logic fire;
    logic hands_idle;
  } trk_status_t;

endpackage

### rtl/core/gcq_action_map.sv
module gcq_action_map (
  input  logic              hand_side,
  input  logic [2:0]        label_code,
  input  logic [2:0]        pose_mode,
  output gcq_pkg::action_t  action
);

  always_comb begin
    action = gcq_pkg::ACT_NONE;
    case (pose_mode)
      gcq_pkg::POSE_FACE: begin
        case (label_code)
          gcq_pkg::LABEL_ILOVEYOU:    action = gcq_pkg::ACT_POWER_CONFIRM;
          gcq_pkg::LABEL_OPEN_PALM:   action = gcq_pkg::ACT_GO_INTRO;
          gcq_pkg::LABEL_CLOSED_FIST: action = gcq_pkg::ACT_GO_INTERVIEW;
          gcq_pkg::LABEL_POINT_UP: begin
            action = (hand_side == gcq_pkg::SIDE_NEAR) ? gcq_pkg::ACT_PROFILE_NEAR
                                                       : gcq_pkg::ACT_PROFILE_FAR;
          end
          default: action = gcq_pkg::ACT_NONE;
        endcase
      end
      gcq_pkg::POSE_INTRO, gcq_pkg::POSE_INTERVIEW: begin
        action = (label_code == gcq_pkg::LABEL_ILOVEYOU) ? gcq_pkg::ACT_POWER_CONFIRM
                                                          : gcq_pkg::ACT_NONE;
      end
      default: action = gcq_pkg::ACT_NONE;
    endcase
  end

endmodule

### rtl/core/gcq_hand_tracker.sv
module gcq_hand_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step_en,
  input  gcq_pkg::cfg_t         cfg,
  input  gcq_pkg::item_t        item,
  output gcq_pkg::action_t      fire_action,
  output gcq_pkg::trk_status_t  status
);

  logic [31:0]      gen_r;
  gcq_pkg::action_t cand_r [2];
  logic [3:0]       cnt_r  [2];
  logic [63:0]      last_r;

  logic [31:0]      gen_nxt;
  gcq_pkg::action_t cand_nxt [2];
  logic [3:0]       cnt_nxt  [2];
  logic [63:0]      last_nxt;

  gcq_pkg::action_t mapped;
  gcq_pkg::action_t act;
  gcq_pkg::action_t cand_base [2];
  logic [3:0]       cnt_base  [2];
  logic [3:0]       run;
  logic [63:0]      diff;
  logic             in_cool;
  logic             fire;

  gcq_action_map u_map (
    .hand_side  (item.hand_side),
    .label_code (item.label_code),
    .pose_mode  (item.pose_mode),
    .action     (mapped)
  );

  always_comb begin
    gen_nxt = item.generation;
    for (int i = 0; i < 2; i++) begin
      cand_base[i] = (item.generation != gen_r) ? gcq_pkg::ACT_NONE : cand_r[i];
      cnt_base[i]  = (item.generation != gen_r) ? 4'd0 : cnt_r[i];
    end
    act = (item.score_q >= cfg.score_threshold) ? mapped : gcq_pkg::ACT_NONE;

    if (cand_base[item.hand_side] == act) begin
      run = (cnt_base[item.hand_side] == gcq_pkg::RUN_MAX) ? gcq_pkg::RUN_MAX
                                                           : cnt_base[item.hand_side] + 4'd1;
    end else begin
      run = 4'd1;
    end

    // wrapping elapsed time against the 32-bit cooldown window
    diff    = item.time_us - last_r;
    in_cool = (last_r != 64'd0) && (diff[63:32] == 32'd0) &&
              (diff[31:0] < cfg.cooldown_us);
    fire    = (act != gcq_pkg::ACT_NONE) && (run >= cfg.confirm_count) && !in_cool;

    cand_nxt = cand_base;
    cnt_nxt  = cnt_base;
    last_nxt = last_r;
    if (act == gcq_pkg::ACT_NONE) begin
      cand_nxt[item.hand_side] = gcq_pkg::ACT_NONE;
      cnt_nxt[item.hand_side]  = 4'd0;
    end else begin
      cand_nxt[item.hand_side] = act;
      cnt_nxt[item.hand_side]  = run;
    end
    if (fire) begin
      last_nxt = item.time_us;
      for (int i = 0; i < 2; i++) begin
        cand_nxt[i] = gcq_pkg::ACT_NONE;
        cnt_nxt[i]  = 4'd0;
      end
    end

    fire_action       = fire ? act : gcq_pkg::ACT_NONE;
    status.step       = step_en;
    status.fire       = fire;
    status.hands_idle = (cnt_r[0] == 4'd0) && (cnt_r[1] == 4'd0) &&
                        (cand_r[0] == gcq_pkg::ACT_NONE) &&
                        (cand_r[1] == gcq_pkg::ACT_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r  <= 32'd0;
      last_r <= 64'd0;
      for (int i = 0; i < 2; i++) begin
        cand_r[i] <= gcq_pkg::ACT_NONE;
        cnt_r[i]  <= 4'd0;
      end
    end else if (step_en) begin
      gen_r  <= gen_nxt;
      last_r <= last_nxt;
      for (int i = 0; i < 2; i++) begin
        cand_r[i] <= cand_nxt[i];
        cnt_r[i]  <= cnt_nxt[i];
      end
    end
  end

endmodule

### rtl/core/gesture_command_qualifier.sv
// gesture command qualifier
// input channel: in_valid / in_stall with one classified detection per transfer
//   (hand side, label code, score, pose mode, generation, timestamp)
// output channel: out_valid / out_stall, one action code per input transfer,
//   in input order; action 0 means nothing fired
// config channel: cfg_valid / cfg_ready, cfg_index selects score threshold (0),
//   confirm count (1) or cooldown in us (2); cfg_ready is always high and
//   writes are expected only while the block is idle
// an input transfer loads the input register; the hand update then loads the
//   result register and raises out_valid; throughput is one detection per cycle
//   while out_stall is low; the per-hand read-modify-write and 64-bit cooldown
//   subtract sit in the single stage between the two registers
// reset (rst_n low, synchronous): config and valid registers go to defaults, both
//   hands and the generation are cleared, last fire time reads as never fired
// out_stall holds the result register; one more detection is still taken into
//   the input register, after which in_stall rises until the result moves
module gesture_command_qualifier (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_hand_side,
  input  logic [2:0]  in_label_code,
  input  logic [9:0]  in_score_q,
  input  logic [2:0]  in_pose_mode,
  input  logic [31:0] in_generation,
  input  logic [63:0] in_time_us,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  `include "assert_macros.svh"

  gcq_pkg::cfg_t        cfg_r;
  gcq_pkg::item_t       item_r;
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  gcq_pkg::action_t     out_action_r;
  gcq_pkg::action_t     fire_action;
  gcq_pkg::trk_status_t trk_status;
  logic                 out_ready;
  logic                 s2_load;
  logic                 in_xfer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.score_threshold <= gcq_pkg::RST_SCORE_THRESHOLD;
      cfg_r.confirm_count   <= gcq_pkg::RST_CONFIRM_COUNT;
      cfg_r.cooldown_us     <= gcq_pkg::RST_COOLDOWN_US;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gcq_pkg::CFG_SCORE_THRESHOLD: cfg_r.score_threshold <= cfg_data[9:0];
        gcq_pkg::CFG_CONFIRM_COUNT:   cfg_r.confirm_count   <= cfg_data[3:0];
        gcq_pkg::CFG_COOLDOWN_US:     cfg_r.cooldown_us     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_ready = !out_valid_r || !out_stall;
  assign s2_load   = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_xfer   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_xfer ? 1'b1 : (s2_load ? 1'b0 : s1_valid_r);
    out_valid_nxt = out_ready ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.hand_side  <= in_hand_side;
      item_r.label_code <= in_label_code;
      item_r.score_q    <= in_score_q;
      item_r.pose_mode  <= in_pose_mode;
      item_r.generation <= in_generation;
      item_r.time_us    <= in_time_us;
    end
    if (s2_load) begin
      out_action_r <= fire_action;
    end
  end

  gcq_hand_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_en     (s2_load),
    .cfg         (cfg_r),
    .item        (item_r),
    .fire_action (fire_action),
    .status      (trk_status)
  );

  assign out_valid  = out_valid_r;
  assign out_action = out_action_r;

  `ASSERT_IMPLY(a_stall_needs_item, clk, rst_n, in_stall, s1_valid_r)
  `ASSERT_NEXT(a_load_gives_result, clk, rst_n, s2_load, out_valid_r)
  `ASSERT_NEXT(a_fire_clears, clk, rst_n, trk_status.step && trk_status.fire, trk_status.hands_idle)
  `ASSERT_IMPLY(a_action_range, clk, rst_n, out_valid_r, out_action_r <= gcq_pkg::ACT_PROFILE_FAR)

endmodule

### dv/gesture_command_qualifier_tb.sv
module gesture_command_qualifier_tb;
  timeunit 1ns;
  timeprecision 1ps;

  class gesture_scoreboard;
    logic [9:0]         thr;
    logic [3:0]         need;
    logic [31:0]        cool;
    logic [31:0]        gen_seen;
    gcq_pkg::action_t   cand [2];
    logic [3:0]         run [2];
    logic [63:0]        last_fire;
    gcq_pkg::action_t   expected_actions [$];
    int unsigned        errors;

    function new();
      thr = gcq_pkg::RST_SCORE_THRESHOLD;
      need = gcq_pkg::RST_CONFIRM_COUNT;
      cool = gcq_pkg::RST_COOLDOWN_US;
      gen_seen = '0;
      last_fire = '0;
      errors = 0;
      clear_hands();
    endfunction

    function void clear_hands();
      cand[0] = gcq_pkg::ACT_NONE;
      cand[1] = gcq_pkg::ACT_NONE;
      run[0] = '0;
      run[1] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] data);
      case (idx)
        gcq_pkg::CFG_SCORE_THRESHOLD: thr = data[9:0];
        gcq_pkg::CFG_CONFIRM_COUNT: need = data[3:0];
        gcq_pkg::CFG_COOLDOWN_US: cool = data;
        default: ;
      endcase
    endfunction

    function gcq_pkg::action_t lookup_gesture(logic side, logic [2:0] label,
                                              logic [2:0] mode);
      if (mode == gcq_pkg::POSE_INTRO || mode == gcq_pkg::POSE_INTERVIEW) begin
        return (label == gcq_pkg::LABEL_ILOVEYOU) ? gcq_pkg::ACT_POWER_CONFIRM
                                                  : gcq_pkg::ACT_NONE;
      end
      if (mode != gcq_pkg::POSE_FACE) return gcq_pkg::ACT_NONE;
      case (label)
        gcq_pkg::LABEL_ILOVEYOU: return gcq_pkg::ACT_POWER_CONFIRM;
        gcq_pkg::LABEL_OPEN_PALM: return gcq_pkg::ACT_GO_INTRO;
        gcq_pkg::LABEL_CLOSED_FIST: return gcq_pkg::ACT_GO_INTERVIEW;
        gcq_pkg::LABEL_POINT_UP: begin
          return (side == gcq_pkg::SIDE_NEAR) ? gcq_pkg::ACT_PROFILE_NEAR
                                              : gcq_pkg::ACT_PROFILE_FAR;
        end
        default: return gcq_pkg::ACT_NONE;
      endcase
    endfunction

    function gcq_pkg::action_t qualify_detection(gcq_pkg::item_t it);
      gcq_pkg::action_t act;
      int s;
      s = int'(it.hand_side);
      if (it.generation != gen_seen) begin
        clear_hands();
        gen_seen = it.generation;
      end
      act = (it.score_q >= thr) ? lookup_gesture(it.hand_side, it.label_code, it.pose_mode)
                                : gcq_pkg::ACT_NONE;
      if (act == gcq_pkg::ACT_NONE) begin
        cand[s] = gcq_pkg::ACT_NONE;
        run[s] = '0;
        return gcq_pkg::ACT_NONE;
      end
      if (cand[s] == act) begin
        if (run[s] < gcq_pkg::RUN_MAX) run[s]++;
      end else begin
        cand[s] = act;
        run[s] = 4'd1;
      end
      if (run[s] < need) return gcq_pkg::ACT_NONE;
      // cooldown window, timestamps wrap at 64 bits
      if (last_fire != '0 && (it.time_us - last_fire) < {32'd0, cool}) begin
        return gcq_pkg::ACT_NONE;
      end
      last_fire = it.time_us;
      clear_hands();
      return act;
    endfunction

    function void note_detection(gcq_pkg::item_t it);
      expected_actions.push_back(qualify_detection(it));
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    task check_action(logic [2:0] got);
      gcq_pkg::action_t want;
      if (expected_actions.size() == 0) begin
        report($sformatf("action %0d with no detection pending", got));
        return;
      end
      want = expected_actions.pop_front();
      if (got !== want) report($sformatf("action %0d, predicted %0d", got, want));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_hand_side = 1'b0;
  logic [2:0]  in_label_code = '0;
  logic [9:0]  in_score_q = '0;
  logic [2:0]  in_pose_mode = '0;
  logic [31:0] in_generation = '0;
  logic [63:0] in_time_us = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = gcq_pkg::CFG_SCORE_THRESHOLD;
  logic [31:0] cfg_data = '0;

  gesture_scoreboard sb;
  int          idle_pct = 0;
  int          stall_pct = 0;
  logic [2:0]  hand_label [2] = '{gcq_pkg::LABEL_OPEN_PALM, gcq_pkg::LABEL_POINT_UP};
  logic [2:0]  cur_mode = gcq_pkg::POSE_FACE;
  logic [31:0] gen_cur = '0;
  logic [63:0] now_us = 64'd1000;

  gesture_command_qualifier u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_hand_side  (in_hand_side),
    .in_label_code (in_label_code),
    .in_score_q    (in_score_q),
    .in_pose_mode  (in_pose_mode),
    .in_generation (in_generation),
    .in_time_us    (in_time_us),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_action(out_action);
  end

  function automatic gcq_pkg::item_t mk(logic side, logic [2:0] label, logic [9:0] score,
                                        logic [2:0] mode, logic [31:0] gen, logic [63:0] t);
    gcq_pkg::item_t it;
    it.hand_side = side;
    it.label_code = label;
    it.score_q = score;
    it.pose_mode = mode;
    it.generation = gen;
    it.time_us = t;
    return it;
  endfunction

  // mostly steady streaks per hand, some noise and weak scores
  function automatic gcq_pkg::item_t next_detection();
    gcq_pkg::item_t it;
    logic [9:0] thr;
    thr = sb.thr;
    if ($urandom_range(99) < 3) gen_cur = $urandom_range(1) ? gen_cur + 32'd1 : 32'($urandom);
    if ($urandom_range(99) < 2) now_us = {$urandom, $urandom};
    else now_us = now_us + ({$urandom, $urandom} >> $urandom_range(62, 28));
    it.generation = gen_cur;
    it.time_us = now_us;
    if ($urandom_range(99) < 8) begin
      it.hand_side = 1'($urandom_range(1));
      it.label_code = 3'($urandom_range(7));
      it.pose_mode = 3'($urandom_range(7));
      it.score_q = 10'($urandom_range(1023));
      return it;
    end
    if ($urandom_range(99) < 5) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4, 5: cur_mode = gcq_pkg::POSE_FACE;
        6, 7: cur_mode = gcq_pkg::POSE_INTRO;
        8: cur_mode = gcq_pkg::POSE_INTERVIEW;
        default: cur_mode = 3'($urandom_range(7, 3));
      endcase
    end
    it.hand_side = 1'($urandom_range(1));
    if ($urandom_range(99) < 6) begin
      if ($urandom_range(9) == 0) hand_label[it.hand_side] = 3'($urandom_range(7));
      else hand_label[it.hand_side] = 3'($urandom_range(4, 1));
    end
    it.label_code = hand_label[it.hand_side];
    it.pose_mode = cur_mode;
    if (thr != '0 && $urandom_range(99) < 6) it.score_q = 10'($urandom_range(thr - 1, 0));
    else it.score_q = 10'($urandom_range(1023, thr));
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input gcq_pkg::item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_hand_side <= it.hand_side;
    in_label_code <= it.label_code;
    in_score_q <= it.score_q;
    in_pose_mode <= it.pose_mode;
    in_generation <= it.generation;
    in_time_us <= it.time_us;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_detection(it);
    @(negedge clk);
  endtask

  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    while (sb.expected_actions.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic set_regs(input logic [9:0] thr, input logic [3:0] cc, input logic [31:0] cd);
    logic [1:0]  regs [3];
    logic [31:0] vals [3];
    regs = '{gcq_pkg::CFG_SCORE_THRESHOLD, gcq_pkg::CFG_CONFIRM_COUNT,
             gcq_pkg::CFG_COOLDOWN_US};
    vals = '{{22'd0, thr}, {28'd0, cc}, cd};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(regs[i], vals[i]);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic random_run(input int n, input int idle, input int stall);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) send_item(next_detection());
    wait_idle(4);
  endtask

  initial begin
    sb = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // fire at time zero, then a fire right after it since zero reads as never fired
    for (int k = 0; k < 3; k++) begin
      send_item(mk(1'b0, gcq_pkg::LABEL_ILOVEYOU, 10'd1023, gcq_pkg::POSE_FACE, '0, '0));
    end
    for (int k = 0; k < 3; k++) begin
      send_item(mk(1'b1, gcq_pkg::LABEL_POINT_UP, 10'd717, gcq_pkg::POSE_FACE, '0, 64'd1));
    end
    // held off by cooldown, run kept
    for (int k = 0; k < 3; k++) begin
      send_item(mk(1'b0, gcq_pkg::LABEL_POINT_UP, 10'd1023, gcq_pkg::POSE_FACE, '0,
                   64'(k + 2)));
    end
    send_item(mk(1'b0, gcq_pkg::LABEL_POINT_UP, 10'd716, gcq_pkg::POSE_FACE, '0, 64'd5));
    send_item(mk(1'b0, gcq_pkg::LABEL_OPEN_PALM, 10'd1023, gcq_pkg::POSE_INTRO, '0, 64'd6));
    send_item(mk(1'b1, gcq_pkg::LABEL_ILOVEYOU, 10'd1023, gcq_pkg::POSE_INTERVIEW, '0,
                 64'd7));
    send_item(mk(1'b0, gcq_pkg::LABEL_CLOSED_FIST, 10'd1023, 3'd3, '0, 64'd8));
    send_item(mk(1'b1, gcq_pkg::LABEL_ILOVEYOU, 10'd1023, 3'd4, '0, 64'd9));
    send_item(mk(1'b0, 3'd7, 10'd1023, 3'd7, '0, 64'd10));
    send_item(mk(1'b1, 3'd5, 10'd1023, gcq_pkg::POSE_FACE, '0, 64'd11));
    send_item(mk(1'b0, 3'd6, 10'd1023, gcq_pkg::POSE_FACE, '0, 64'd12));
    // generation change clears both hands mid-run
    send_item(mk(1'b0, gcq_pkg::LABEL_OPEN_PALM, 10'd1023, gcq_pkg::POSE_FACE, '1, 64'd13));
    send_item(mk(1'b0, gcq_pkg::LABEL_OPEN_PALM, 10'd1023, gcq_pkg::POSE_FACE, '1,
                 64'hFFFF_FFFF_FFFF_FFF0));
    send_item(mk(1'b0, gcq_pkg::LABEL_OPEN_PALM, 10'd1023, gcq_pkg::POSE_FACE, '1, '1));
    // wrapped timestamp still inside cooldown
    for (int k = 0; k < 3; k++) begin
      send_item(mk(1'b0, gcq_pkg::LABEL_CLOSED_FIST, 10'd1023, gcq_pkg::POSE_FACE, '1,
                   64'(k + 5)));
    end
    send_item(mk(1'b1, 3'd0, 10'd0, gcq_pkg::POSE_FACE, '1, 64'd9));
    wait_idle(4);

    random_run(113, 0, 0);
    set_regs(10'd0, 4'd1, 32'd0);
    random_run(113, 64, 0);
    set_regs(10'd1023, 4'd15, 32'hFFFF_FFFF);
    random_run(113, 0, 64);
    set_regs(10'd512, 4'd0, 32'd1000);
    random_run(113, 22, 22);
    set_regs(10'd700, 4'd2, 32'd200);
    random_run(113, 0, 0);
    set_regs(10'($urandom), 4'($urandom_range(15, 1)), 32'($urandom_range(5000000)));
    random_run(113, 64, 0);

    stall_pct = 0;
    wait_idle(8);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/gcq_pkg.sv
rtl/core/gcq_action_map.sv
rtl/core/gcq_hand_tracker.sv
rtl/core/gesture_command_qualifier.sv
dv/gesture_command_qualifier_tb.sv
